// File: rtl/dlp_pkg.sv
// Shared types and constants for the DAG longest-path block.
package dlp_pkg;
   localparam int NumVertices = 16;
   localparam int VtxBits = 4;
   localparam int WeightBits = 16;
   localparam int DistBits = 20;
   localparam int EdgeAddrBits = 2 * VtxBits;
   localparam logic signed [DistBits-1:0] DistMax = 20'sh7FFFF;
   localparam logic signed [DistBits-1:0] DistMin = 20'sh80000;
   localparam logic [0:0] ActEdge = 1'b0;
   localparam logic [0:0] ActRun = 1'b1;
   localparam logic [0:0] RegSource = 1'b0;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DFS_START, ST_DFS_SCAN, ST_REL_INIT, ST_REL_NEXT,
      ST_REL_SCAN, ST_REL_READ, ST_REL_CALC, ST_EMIT
   } state_type;

   typedef struct packed {
      logic [0:0] action;
      logic [VtxBits-1:0] from_vertex;
      logic [VtxBits-1:0] to_vertex;
      logic signed [WeightBits-1:0] edge_weight;
   } req_type;

   typedef struct packed {
      logic [VtxBits-1:0] vertex_index;
      logic signed [DistBits-1:0] distance;
      logic reachable;
      logic last;
   } rsp_type;
endpackage

// File: rtl/dlp_req_if.sv
// Request channel interface.
interface dlp_req_if;
   logic valid;
   logic ready;
   dlp_pkg::req_type req_payload;
   modport source (output valid, output req_payload, input ready);
   modport sink (input valid, input req_payload, output ready);
endinterface

// File: rtl/dlp_rsp_if.sv
// Result channel interface.
interface dlp_rsp_if;
   logic valid;
   logic ready;
   dlp_pkg::rsp_type rsp_payload;
   modport source (output valid, output rsp_payload, input ready);
   modport sink (input valid, input rsp_payload, output ready);
endinterface

// File: rtl/dag_longest_path_top.sv
// Top level of the DAG longest-path block.
// Edge requests (action 0) are taken one per cycle while idle and write the weight
// RAM and presence matrix. A run request (action 1) holds the block: a DFS sequencer
// scans one candidate neighbor per cycle, then a relaxation pass walks the reverse
// postorder, one candidate edge per cycle except that each present edge also goes
// through the RAM read and the single saturating adder/compare unit, then 16
// results go out one per accepted handshake. req.ready is low from run accept until
// the last result is taken.
module dag_longest_path_top (
   input logic clock,
   input logic reset,
   dlp_req_if.sink req,
   dlp_rsp_if.source rsp,
   input logic csr_psel,
   input logic csr_penable,
   input logic csr_pwrite,
   input logic [1:0] csr_paddr,
   input logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic csr_pready
);
   localparam int VB = dlp_pkg::VtxBits;
   localparam int NV = dlp_pkg::NumVertices;
   localparam int DB = dlp_pkg::DistBits;

   dlp_pkg::state_type state_ff, state_in;
   logic [VB-1:0] source_ff;
   logic [NV-1:0] present_ff [NV];
   logic [NV-1:0] visited_ff;
   logic [NV-1:0] reach_ff;
   logic [VB-1:0] stk_v_ff [NV];  // vertex per DFS level
   logic [VB:0] stk_j_ff [NV];    // next neighbor index per level
   logic [VB:0] sp_ff;
   logic [VB:0] start_ff;
   logic [VB-1:0] topo_ff [NV];
   logic [VB:0] pc_ff;
   logic signed [DB-1:0] dist_ff [NV];
   logic [VB:0] idx_ff;      // topo walk index / emit index
   logic [VB-1:0] u_ff;
   logic [VB:0] v_ff;

   // config port
   assign csr_pready = 1'b1;
   wire csr_wr = csr_psel && csr_penable && csr_pwrite;
   always_ff @(posedge clock) begin
      if (reset) source_ff <= VB'(1);
      else if (csr_wr && csr_paddr == {dlp_pkg::RegSource, 1'b0})
         source_ff <= csr_pwdata[VB-1:0];
   end
   assign csr_prdata = (csr_paddr == {dlp_pkg::RegSource, 1'b0}) ? 32'(source_ff) : '0;

   wire req_fire = req.valid && req.ready;
   wire is_edge = req.req_payload.action == dlp_pkg::ActEdge;
   assign req.ready = (state_ff == dlp_pkg::ST_IDLE);

   // weight RAM
   logic [dlp_pkg::WeightBits-1:0] w_rd;
   dlp_ram #(.Width(dlp_pkg::WeightBits), .Depth(NV*NV)) u_wram (
      .clock(clock),
      .wr_en(req_fire && is_edge),
      .wr_addr({req.req_payload.from_vertex, req.req_payload.to_vertex}),
      .wr_data(req.req_payload.edge_weight),
      .rd_addr({u_ff, v_ff[VB-1:0]}),
      .rd_data(w_rd)
   );

   // DFS view of top of stack
   wire [VB-1:0] top_v = stk_v_ff[sp_ff[VB-1:0] - VB'(1)];
   wire [VB:0] top_j = stk_j_ff[sp_ff[VB-1:0] - VB'(1)];
   wire scan_end = top_j[VB];
   wire [VB-1:0] jv = top_j[VB-1:0];
   wire scan_hit = !scan_end && present_ff[top_v][jv] && !visited_ff[jv];

   // shared saturating adder/compare
   wire signed [DB:0] sum = {dist_ff[u_ff][DB-1], dist_ff[u_ff]} +
                            (DB+1)'($signed(w_rd));
   logic signed [DB-1:0] cand;
   always_comb begin
      if (sum > (DB+1)'(dlp_pkg::DistMax)) cand = dlp_pkg::DistMax;
      else if (sum < (DB+1)'(dlp_pkg::DistMin)) cand = dlp_pkg::DistMin;
      else cand = sum[DB-1:0];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dlp_pkg::ST_IDLE:
            if (req_fire && !is_edge) state_in = dlp_pkg::ST_DFS_START;
         dlp_pkg::ST_DFS_START:
            if (start_ff[VB]) state_in = dlp_pkg::ST_REL_INIT;
            else if (!visited_ff[start_ff[VB-1:0]]) state_in = dlp_pkg::ST_DFS_SCAN;
         dlp_pkg::ST_DFS_SCAN:
            if (!scan_hit && scan_end && sp_ff == (VB+1)'(1))
               state_in = dlp_pkg::ST_DFS_START;
         dlp_pkg::ST_REL_INIT: state_in = dlp_pkg::ST_REL_NEXT;
         dlp_pkg::ST_REL_NEXT:
            if (idx_ff[VB]) state_in = dlp_pkg::ST_EMIT;
            else if (reach_ff[topo_ff[idx_ff[VB-1:0]]]) state_in = dlp_pkg::ST_REL_SCAN;
         dlp_pkg::ST_REL_SCAN:
            if (v_ff[VB]) state_in = dlp_pkg::ST_REL_NEXT;
            else if (present_ff[u_ff][v_ff[VB-1:0]]) state_in = dlp_pkg::ST_REL_READ;
         dlp_pkg::ST_REL_READ: state_in = dlp_pkg::ST_REL_CALC;
         dlp_pkg::ST_REL_CALC: state_in = dlp_pkg::ST_REL_SCAN;
         dlp_pkg::ST_EMIT:
            if (rsp.ready && idx_ff == (VB+1)'(NV-1)) state_in = dlp_pkg::ST_IDLE;
         default: state_in = dlp_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      rsp.valid = (state_ff == dlp_pkg::ST_EMIT);
      rsp.rsp_payload.vertex_index = idx_ff[VB-1:0];
      rsp.rsp_payload.reachable = reach_ff[idx_ff[VB-1:0]];
      rsp.rsp_payload.distance = reach_ff[idx_ff[VB-1:0]] ? dist_ff[idx_ff[VB-1:0]] : '0;
      rsp.rsp_payload.last = (idx_ff == (VB+1)'(NV-1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dlp_pkg::ST_IDLE;
         for (int i = 0; i < NV; i++) present_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         if (req_fire && is_edge)
            present_ff[req.req_payload.from_vertex][req.req_payload.to_vertex] <= 1'b1;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      unique case (state_ff)
         dlp_pkg::ST_IDLE: begin
            visited_ff <= '0;
            start_ff <= '0;
            sp_ff <= '0;
            pc_ff <= '0;
         end
         dlp_pkg::ST_DFS_START: begin
            if (!start_ff[VB]) begin
               if (!visited_ff[start_ff[VB-1:0]]) begin
                  visited_ff[start_ff[VB-1:0]] <= 1'b1;
                  stk_v_ff[0] <= start_ff[VB-1:0];
                  stk_j_ff[0] <= '0;
                  sp_ff <= (VB+1)'(1);
               end
               start_ff <= start_ff + 1'b1;
            end
         end
         dlp_pkg::ST_DFS_SCAN: begin
            if (scan_hit) begin
               // stack cannot overflow: each vertex pushed once
               stk_j_ff[sp_ff[VB-1:0] - VB'(1)] <= top_j + 1'b1;
               visited_ff[jv] <= 1'b1;
               stk_v_ff[sp_ff[VB-1:0]] <= jv;
               stk_j_ff[sp_ff[VB-1:0]] <= '0;
               sp_ff <= sp_ff + 1'b1;
            end else if (scan_end) begin
               // reverse postorder: fill topo from the back
               topo_ff[VB'(NV-1) - pc_ff[VB-1:0]] <= top_v;
               pc_ff <= pc_ff + 1'b1;
               sp_ff <= sp_ff - 1'b1;
            end else begin
               stk_j_ff[sp_ff[VB-1:0] - VB'(1)] <= top_j + 1'b1;
            end
         end
         dlp_pkg::ST_REL_INIT: begin
            for (int i = 0; i < NV; i++) dist_ff[i] <= '0;
            reach_ff <= NV'(1) << source_ff;
            idx_ff <= '0;
         end
         dlp_pkg::ST_REL_NEXT: begin
            if (!idx_ff[VB]) begin
               u_ff <= topo_ff[idx_ff[VB-1:0]];
               v_ff <= '0;
               idx_ff <= idx_ff + 1'b1;
            end else idx_ff <= '0;
         end
         dlp_pkg::ST_REL_SCAN:
            if (!v_ff[VB] && !present_ff[u_ff][v_ff[VB-1:0]]) v_ff <= v_ff + 1'b1;
         dlp_pkg::ST_REL_READ: ;
         dlp_pkg::ST_REL_CALC: begin
            if (!reach_ff[v_ff[VB-1:0]] || dist_ff[v_ff[VB-1:0]] < cand) begin
               dist_ff[v_ff[VB-1:0]] <= cand;
               reach_ff[v_ff[VB-1:0]] <= 1'b1;
            end
            v_ff <= v_ff + 1'b1;
         end
         dlp_pkg::ST_EMIT:
            if (rsp.ready) idx_ff <= idx_ff + 1'b1;
         default: ;
      endcase
   end

   // assertions
   a_no_req_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != dlp_pkg::ST_IDLE |-> !req.ready)
      else $error("request taken while busy");
   a_sp_bound: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= (VB+1)'(NV))
      else $error("DFS stack overflow");
   a_emit_done: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.ready && rsp.rsp_payload.last |=> state_ff == dlp_pkg::ST_IDLE)
      else $error("run did not finish after last result");
endmodule

// File: rtl/dlp_ram.sv
// Generic single-port-write RAM with registered read.
module dlp_ram #(
   parameter int Width = 16,
   parameter int Depth = 256
) (
   input logic clock,
   input logic wr_en,
   input logic [$clog2(Depth)-1:0] wr_addr,
   input logic [Width-1:0] wr_data,
   input logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0] rd_data
);
   logic [Width-1:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
